### hw/rtl/dcp_pkg.sv
// Shared constants and types for the decreasing chain partitioner.
`timescale 1ns / 1ps

package dcp_pkg;

    localparam int MAX_TRACKS = 64;
    localparam int VALUE_BITS = 16;

    // Track address and track count widths
    localparam int IDX_W = $clog2(MAX_TRACKS);
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);

    // Fixed port widths
    localparam int CAR_W = 16;
    localparam int TRK_W = 7;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // Track top memory access from the search engine
    typedef struct packed {
        logic   rd_en;
        idx_t   rd_addr;
        logic   wr_en;
        idx_t   wr_addr;
        value_t wr_data;
    } mem_req_t;

    // One placement result
    typedef struct packed {
        logic [TRK_W-1:0] track_index;
        logic             in_first_chain;
        logic [TRK_W-1:0] tracks_used;
        logic             overflow;
        logic             done_res;
    } res_t;

endpackage

### hw/rtl/dcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/dcp_search.sv
// Binary search over the track tops, placement and track count bookkeeping.
`timescale 1ns / 1ps

module dcp_search (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [15:0]            car_value,
    input  logic                   last,
    output dcp_pkg::mem_req_t      req,
    input  dcp_pkg::value_t        rd_data,
    input  logic                   res_free,
    output logic                   res_valid,
    output dcp_pkg::res_t          res
);
    import dcp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_PLACE
    } state_t;

    state_t state_reg, state_next;
    cnt_t   lo_reg, lo_next;
    cnt_t   hi_reg, hi_next;
    cnt_t   mid_reg, mid_next;
    cnt_t   open_reg, open_next;
    logic   ovf_reg, ovf_next;
    value_t value_reg, value_next;
    logic   last_reg, last_next;

    cnt_t   mid;
    cnt_t   pos;
    cnt_t   open_after;
    logic   ovf_after;
    logic   [CNT_W:0] pos_plus;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign in_stall = (state_reg != ST_IDLE);

    // Placement once the search has converged on lo
    always_comb
    begin
        pos        = lo_reg;
        open_after = open_reg;
        ovf_after  = ovf_reg;
        if (lo_reg >= open_reg)
        begin
            if (open_reg < CNT_W'(MAX_TRACKS))
            begin
                pos        = open_reg;
                open_after = open_reg + CNT_W'(1);
            end
            else
            begin
                // all tracks open: saturate onto the last one
                pos       = CNT_W'(MAX_TRACKS - 1);
                ovf_after = 1'b1;
            end
        end
    end

    assign pos_plus = {1'b0, pos} + (CNT_W+1)'(1);

    always_comb
    begin
        res.track_index    = TRK_W'(pos_plus);
        res.in_first_chain = (pos == '0);
        res.tracks_used    = TRK_W'(open_after);
        res.overflow       = ovf_after;
        res.done_res       = last_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        open_next   = open_reg;
        ovf_next    = ovf_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        req.rd_en   = 1'b0;
        req.rd_addr = IDX_W'(mid);
        req.wr_en   = 1'b0;
        req.wr_addr = IDX_W'(pos);
        req.wr_data = value_reg;
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = VALUE_BITS'(car_value);
                    last_next  = last;
                    lo_next    = '0;
                    hi_next    = open_reg;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    req.rd_en  = 1'b1;
                    mid_next   = mid;
                    state_next = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_COMPARE:
            begin
                if (rd_data > value_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                state_next = ST_SEARCH;
            end
            ST_PLACE:
            begin
                if (res_free)
                begin
                    req.wr_en  = 1'b1;
                    res_valid  = 1'b1;
                    open_next  = last_reg ? '0 : open_after;
                    ovf_next   = last_reg ? 1'b0 : ovf_after;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            open_reg  <= '0;
            ovf_reg   <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            ovf_reg   <= ovf_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg   <= mid_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    a_open_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= CNT_W'(MAX_TRACKS))
        else $error("open track count above capacity");

    a_compare_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COMPARE |-> $past(req.rd_en))
        else $error("compare without a preceding memory read");

    a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> lo_reg <= hi_reg && hi_reg <= open_reg)
        else $error("search window out of order");

    a_result_in_place: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> state_reg == ST_PLACE && req.wr_en && pos < CNT_W'(MAX_TRACKS))
        else $error("result issued outside placement");

endmodule

### hw/rtl/decreasing_chain_partitioner.sv
// Top level: track top memory, search engine and output register.
//
// Splits a stream of car numbers into the fewest strictly decreasing chains.
// Input channel: in_valid / in_stall with car_value and last. Output channel:
// out_valid / out_stall with track_index, in_first_chain, tracks_used,
// overflow and done_res, one result transaction per input transaction.
// One element is handled at a time. Each binary search step is one read of
// the track top memory (registered read data) followed by one compare.
// The next element can be accepted in the cycle after a result is produced.
// The result sits in an output register; the next element is accepted while
// it waits, but its own result is held back until the register is free.
// While out_valid and out_stall are both high the output payload holds steady.
// Reset clears the track count and overflow flag; the track top memory needs
// no clearing since only entries below the count are read. An element with
// last set ends the sequence and the count and overflow start afresh.
`timescale 1ns / 1ps

module decreasing_chain_partitioner (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [15:0]               car_value,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [6:0]                track_index,
    output logic                      in_first_chain,
    output logic [6:0]                tracks_used,
    output logic                      overflow,
    output logic                      done_res
);
    import dcp_pkg::*;

    mem_req_t req;
    value_t   rd_data;
    logic     res_free;
    logic     res_valid;
    res_t     res;

    logic     out_valid_reg, out_valid_next;
    res_t     out_reg;

    dcp_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(MAX_TRACKS)
    ) u_tops (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (rd_data)
    );

    dcp_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .car_value (car_value),
        .last      (last),
        .req       (req),
        .rd_data   (rd_data),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res)
    );

    assign res_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign track_index    = out_reg.track_index;
    assign in_first_chain = out_reg.in_first_chain;
    assign tracks_used    = out_reg.tracks_used;
    assign overflow       = out_reg.overflow;
    assign done_res       = out_reg.done_res;

endmodule
